// ===== src/ksps_pkg.sv =====
package ksps_pkg;

  // Command codes carried in the low bits of the input item.
  localparam logic [1:0] FUNC_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_SECOND = 2'd1;
  localparam logic [1:0] FUNC_RUN         = 2'd2;

  localparam int VALUE_W = 32;
  localparam int SUM_W   = 33;
  localparam int CFG_W   = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic clear_run;
    logic seed_push;
    logic pop_start;
    logic emit;
    logic push_next;
    logic step;
    logic end_run;
  } ksps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic arrays_empty;
    logic seed_done;
    logic heap_empty;
    logic sift_done;
    logic has_next;
    logic out_busy;
  } ksps_stat_t;

endpackage

// ===== src/ksps_ctrl.sv =====
module ksps_ctrl
  import ksps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  output logic             in_ready,
  input  logic [CFG_W-1:0] limit,
  input  ksps_stat_t       stat,
  output ksps_cmd_t        cmd,
  output logic             out_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEED = 3'd1;
  localparam logic [2:0] ST_SIFT = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;
  localparam logic [2:0] ST_UP   = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CFG_W-1:0] emitted;
  logic [CFG_W-1:0] emitted_next;

  // Registers for state and emitted pair count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      emitted <= '0;
    end else begin
      state   <= state_next;
      emitted <= emitted_next;
    end
  end

  // Sequencing of seed, pop, emit and push steps.
  always_comb begin
    state_next   = state;
    emitted_next = emitted;
    cmd          = '0;
    in_ready     = 1'b0;
    out_last     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            FUNC_LOAD_FIRST:  cmd.load_first  = 1'b1;
            FUNC_LOAD_SECOND: cmd.load_second = 1'b1;
            FUNC_RUN: begin
              emitted_next = '0;
              if (stat.arrays_empty || limit == '0) begin
                cmd.end_run = 1'b1;
              end else begin
                cmd.clear_run = 1'b1;
                state_next    = ST_SEED;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEED: begin
        if (stat.seed_done) begin
          state_next = ST_EMIT;
        end else begin
          cmd.seed_push = 1'b1;
          state_next    = ST_UP;
        end
      end
      ST_UP: begin
        cmd.step = 1'b1;
        if (stat.sift_done) begin
          state_next = stat.seed_done ? ST_EMIT : ST_SEED;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit     = 1'b1;
          emitted_next = emitted + 1'b1;
          out_last     = (emitted + 1'b1 == limit) ||
                         (stat.heap_empty && !stat.has_next);
          if (out_last) begin
            cmd.end_run = 1'b1;
            state_next  = ST_IDLE;
          end else if (stat.has_next) begin
            cmd.push_next = 1'b1;
            state_next    = ST_SIFT;
          end else begin
            cmd.pop_start = 1'b1;
            state_next    = ST_SIFT;
          end
        end
      end
      ST_SIFT: begin
        cmd.step = 1'b1;
        if (stat.sift_done) begin
          state_next = ST_EMIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/ksps_dp.sv =====
module ksps_dp
  import ksps_pkg::*;
#(
  parameter int ARRAY_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [VALUE_W-1:0] in_value,
  input  ksps_cmd_t          cmd,
  input  logic               out_last,
  output ksps_stat_t         stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [103:0]       out_data,
  output logic               out_tlast
);

  localparam int IW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int CW = $clog2(ARRAY_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(ARRAY_DEPTH);

  typedef struct packed {
    logic [IW-1:0]     fi;
    logic [IW-1:0]     si;
    logic [SUM_W-1:0]  sum;
  } entry_t;

  logic [VALUE_W-1:0] first_store  [ARRAY_DEPTH];
  logic [VALUE_W-1:0] second_store [ARRAY_DEPTH];
  entry_t             heap [ARRAY_DEPTH];
  logic [CW-1:0]      first_count;
  logic [CW-1:0]      second_count;
  logic [CW-1:0]      heap_size;
  logic [CW-1:0]      seed_idx;
  logic [IW-1:0]      pos;
  logic               up_mode;
  logic               sift_active;

  // Ordered compare: smaller sum first, ties to smaller first index.
  function automatic logic less(entry_t a, entry_t b);
    return ($signed(a.sum) < $signed(b.sum)) ||
           (a.sum == b.sum && a.fi < b.fi);
  endfunction

  // Candidate entries built from the stores.
  entry_t seed_e;
  entry_t next_e;
  entry_t top;
  logic [IW+1:0] lc;
  logic [IW+1:0] rc;
  logic [IW-1:0] best;
  logic [IW-1:0] parent;
  logic [IW-1:0] lci;
  logic [IW-1:0] rci;

  assign top = heap[0];
  always_comb begin
    seed_e.fi  = seed_idx[IW-1:0];
    seed_e.si  = '0;
    seed_e.sum = SUM_W'($signed(first_store[seed_idx[IW-1:0]])) +
                 SUM_W'($signed(second_store[0]));
    next_e.fi  = top.fi;
    next_e.si  = top.si + 1'b1;
    next_e.sum = SUM_W'($signed(first_store[top.fi])) +
                 SUM_W'($signed(second_store[IW'(top.si + 1'b1)]));
  end

  // One level of sift per cycle.
  always_comb begin
    lc     = {1'b0, pos, 1'b1};
    rc     = lc + 1'b1;
    lci    = lc[IW-1:0];
    rci    = rc[IW-1:0];
    parent = (pos - 1'b1) >> 1;
    best   = pos;
    if ((IW+2)'(heap_size) > lc && less(heap[lci], heap[pos])) best = lci;
    if ((IW+2)'(heap_size) > rc && less(heap[rci], heap[best])) best = rci;
  end

  assign stat.arrays_empty = (first_count == '0) || (second_count == '0);
  assign stat.seed_done    = (seed_idx == first_count);
  assign stat.heap_empty   = (heap_size == CW'(1));
  assign stat.has_next     = (CW'(top.si) + CW'(1) < second_count);
  assign stat.out_busy     = out_valid && !out_ready;
  assign stat.sift_done    = up_mode ? (pos == '0 || !less(heap[pos], heap[parent]))
                                     : (best == pos);

  // Stores, heap and sift position.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      heap_size    <= '0;
      seed_idx     <= '0;
      pos          <= '0;
      up_mode      <= 1'b0;
    end else begin
      if (cmd.load_first && first_count < DEPTH_C) begin
        first_store[first_count[IW-1:0]] <= in_value;
        first_count <= first_count + 1'b1;
      end
      if (cmd.load_second && second_count < DEPTH_C) begin
        second_store[second_count[IW-1:0]] <= in_value;
        second_count <= second_count + 1'b1;
      end
      if (cmd.clear_run) begin
        heap_size <= '0;
        seed_idx  <= '0;
      end
      if (cmd.seed_push) begin
        heap[heap_size[IW-1:0]] <= seed_e;
        pos       <= heap_size[IW-1:0];
        heap_size <= heap_size + 1'b1;
        seed_idx  <= seed_idx + 1'b1;
        up_mode   <= 1'b1;
      end
      if (cmd.push_next) begin
        heap[0] <= next_e;
        pos     <= '0;
        up_mode <= 1'b0;
      end
      if (cmd.pop_start) begin
        heap[0]   <= heap[IW'(heap_size - 1'b1)];
        heap_size <= heap_size - 1'b1;
        pos       <= '0;
        up_mode   <= 1'b0;
      end
      if (cmd.step && !stat.sift_done) begin
        if (up_mode) begin
          heap[pos]    <= heap[parent];
          heap[parent] <= heap[pos];
          pos          <= parent;
        end else begin
          heap[pos]  <= heap[best];
          heap[best] <= heap[pos];
          pos        <= best;
        end
      end
      if (cmd.end_run) begin
        first_count  <= '0;
        second_count <= '0;
        heap_size    <= '0;
      end
    end
  end

  // Output register holds one finished pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data  <= {7'd0, top.sum, second_store[top.si], first_store[top.fi]};
      out_tlast <= out_last;
    end
  end

endmodule

// ===== src/k_smallest_pair_sums.sv =====
// Loads are taken while idle; a run of first_count F seeds the heap with F pushes,
// each sifted up, then each pair is emitted and the next entry pushed or the heap
// popped and sifted down (the final pair ends the run), one sift level per cycle.
// One item at a time; the output register lets the next sift run while a pair waits.
// Synchronous active-high rst clears counts, heap size and the controller and sets
// pairs_wanted to 1; stores and heap contents are undefined until written.
module k_smallest_pair_sums
  import ksps_pkg::*;
#(
  parameter int ARRAY_DEPTH = 16,
  parameter int MAX_PAIRS   = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [39:0]      s_axis_tdata,  // func[1:0], value[33:2], zero fill
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [103:0]     m_axis_tdata,  // first_value, second_value, pair_sum, zero
  output logic             m_axis_tlast,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0] pairs_wanted;
  logic [CFG_W-1:0] limit;
  ksps_cmd_t        cmd;
  ksps_stat_t       stat;
  logic             out_last;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_wanted <= CFG_W'(1);
    end else if (cfg_we) begin
      pairs_wanted <= cfg_wdata;
    end
  end

  assign limit = (pairs_wanted > CFG_W'(MAX_PAIRS)) ? CFG_W'(MAX_PAIRS) : pairs_wanted;

  ksps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tdata[1:0]),
    .in_ready (s_axis_tready),
    .limit    (limit),
    .stat     (stat),
    .cmd      (cmd),
    .out_last (out_last)
  );

  ksps_dp #(.ARRAY_DEPTH(ARRAY_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_value  (s_axis_tdata[33:2]),
    .cmd       (cmd),
    .out_last  (out_last),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_tlast (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // A pair is only emitted when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pair emitted over a waiting result");

  // Input is never taken while a run is in progress.
  a_no_input_in_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.seed_push) |-> !s_axis_tready)
    else $error("input accepted during a run");
`endif

endmodule

// ===== test/pair_sum_checker.sv =====
module pair_sum_checker
  import ksps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  output int           fail_count,
  output int           pending_pairs,
  output int           pairs_seen,
  output int           runs_seen
);

  typedef struct packed {
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic signed [32:0] pair_sum;
    logic               last;
  } pair_t;

  typedef struct {
    int unsigned fi;
    int unsigned si;
  } slot_t;

  localparam int DEPTH = 16;
  localparam int MAX_PAIRS = 64;

  logic signed [31:0] first_arr [DEPTH];
  logic signed [31:0] second_arr [DEPTH];
  int unsigned first_len, second_len;
  logic [6:0] wanted;
  slot_t heap [DEPTH];
  int unsigned heap_len;
  pair_t expected_pairs [$];

  function automatic longint slot_total(slot_t e);
    return longint'(first_arr[e.fi]) + longint'(second_arr[e.si]);
  endfunction

  // Smaller sum wins; equal sums go to the smaller first index.
  function automatic bit ranks_lower(slot_t a, slot_t b);
    longint sa, sb;
    sa = slot_total(a);
    sb = slot_total(b);
    return sa < sb || (sa == sb && a.fi < b.fi);
  endfunction

  task automatic heap_insert(slot_t e);
    int unsigned pos, up;
    slot_t t;
    if (heap_len >= DEPTH) return;
    pos = heap_len++;
    heap[pos] = e;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!ranks_lower(heap[pos], heap[up])) break;
      t = heap[pos]; heap[pos] = heap[up]; heap[up] = t;
      pos = up;
    end
  endtask

  task automatic heap_take(output slot_t top);
    int unsigned pos, l, r, best;
    slot_t t;
    top = heap[0];
    pos = 0;
    heap_len--;
    heap[0] = heap[heap_len];
    forever begin
      l = 2 * pos + 1; r = l + 1; best = pos;
      if (l < heap_len && ranks_lower(heap[l], heap[best])) best = l;
      if (r < heap_len && ranks_lower(heap[r], heap[best])) best = r;
      if (best == pos) break;
      t = heap[pos]; heap[pos] = heap[best]; heap[best] = t;
      pos = best;
    end
  endtask

  // Work out every pair a run emits and queue them in order.
  task automatic predict_run();
    int unsigned limit, n;
    slot_t e;
    pair_t p;
    heap_len = 0;
    n = 0;
    limit = wanted > MAX_PAIRS ? MAX_PAIRS : wanted;
    if (first_len > 0 && second_len > 0) begin
      for (int unsigned i = 0; i < first_len; i++) begin
        e.fi = i; e.si = 0;
        heap_insert(e);
      end
      while (heap_len > 0 && n < limit) begin
        heap_take(e);
        p.first_value = first_arr[e.fi];
        p.second_value = second_arr[e.si];
        p.pair_sum = 33'(slot_total(e));
        p.last = 1'b0;
        expected_pairs.insert(expected_pairs.size(), p);
        n++;
        if (e.si + 1 < second_len) begin
          e.si++;
          heap_insert(e);
        end
      end
      if (n > 0) expected_pairs[$].last = 1'b1;
    end
    first_len = 0;
    second_len = 0;
  endtask

  assign pending_pairs = expected_pairs.size();

  // Track commands and compare results at each clock edge.
  always @(posedge clk) begin
    pair_t got, want;
    if (rst) begin
      first_len = 0;
      second_len = 0;
      wanted = 7'd1;
      fail_count <= 0;
      pairs_seen <= 0;
      runs_seen <= 0;
      expected_pairs.delete();
    end else begin
      if (cfg_we) wanted = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got.first_value = m_axis_tdata[31:0];
        got.second_value = m_axis_tdata[63:32];
        got.pair_sum = m_axis_tdata[96:64];
        got.last = m_axis_tlast;
        pairs_seen <= pairs_seen + 1;
        if (expected_pairs.size() == 0) begin
          $display("%0t: unexpected pair, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pairs.pop_front();
          if (got !== want || m_axis_tdata[103:97] !== '0) begin
            $display("%0t: pair mismatch, expected %h, actual %h (upper %h)",
                     $time, want, got, m_axis_tdata[103:97]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tdata[1:0])
          FUNC_LOAD_FIRST: begin
            if (first_len < DEPTH) first_arr[first_len++] = s_axis_tdata[33:2];
          end
          FUNC_LOAD_SECOND: begin
            if (second_len < DEPTH) second_arr[second_len++] = s_axis_tdata[33:2];
          end
          FUNC_RUN: begin
            predict_run();
            runs_seen <= runs_seen + 1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import ksps_pkg::*;

  localparam logic [1:0] FUNC_IGNORED = 2'd3;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we;
  logic [6:0]   cfg_wdata;
  int           fail_count, pending_pairs, pairs_seen, runs_seen;
  int           sent;

  k_smallest_pair_sums dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  pair_sum_checker checker_i (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_pairs(pending_pairs),
    .pairs_seen(pairs_seen), .runs_seen(runs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end

  // Receiver waits a random number of cycles before taking each item,
  // with stretches of no stalls.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      gap = (sent % 100 < 30) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Send one item after a random gap and wait for it to be taken.
  // tvalid stays high afterwards so a following item can go back to back.
  task automatic send_item(logic [1:0] func, logic [31:0] value);
    int gap;
    gap = (sent % 100 < 30) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, value, func};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // Stop sending, wait until every predicted pair is out, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pairs != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_wanted(logic [6:0] n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load non-decreasing random arrays of the given sizes and run.
  task automatic sorted_run(int nf, int ns, int span);
    logic signed [31:0] v;
    v = $urandom_range(0, 1) ? -(span * 4) : $urandom;
    if (span == 0) v = $urandom;
    for (int i = 0; i < nf; i++) begin
      send_item(FUNC_LOAD_FIRST, v);
      if (span != 0 && v < 32'sh7fff0000) v = v + $urandom_range(0, span);
    end
    v = $urandom_range(0, 1) ? -(span * 4) : $urandom_range(0, 100);
    for (int i = 0; i < ns; i++) begin
      send_item(FUNC_LOAD_SECOND, v);
      if (span != 0 && v < 32'sh7fff0000) v = v + $urandom_range(0, span);
    end
    send_item(FUNC_RUN, $urandom);
  endtask

  initial begin
    int r;
    sent = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset count of one, field extremes, empty arrays, func 3.
    send_item(FUNC_LOAD_FIRST, 32'h7fffffff);
    send_item(FUNC_LOAD_SECOND, 32'h7fffffff);
    send_item(FUNC_RUN, 32'hffffffff);
    send_item(FUNC_LOAD_FIRST, 32'h80000000);
    send_item(FUNC_LOAD_SECOND, 32'h80000000);
    send_item(FUNC_IGNORED, 32'h5555aaaa);
    send_item(FUNC_RUN, 32'h0);
    set_wanted(7'd64);
    send_item(FUNC_LOAD_FIRST, 32'd5);
    send_item(FUNC_RUN, 32'h0);
    send_item(FUNC_RUN, 32'h0);
    send_item(FUNC_LOAD_FIRST, 32'd3);
    send_item(FUNC_LOAD_FIRST, 32'd1);
    send_item(FUNC_LOAD_SECOND, 32'd2);
    send_item(FUNC_LOAD_SECOND, 32'd2);
    send_item(FUNC_RUN, 32'h0);
    set_wanted(7'd0);
    sorted_run(2, 2, 3);
    set_wanted(7'd127);
    // Overfilled arrays: the seventeenth load of each side is dropped.
    sorted_run(17, 17, 0);
    drain();

    // Random: mostly sorted runs, some noise and unsorted data.
    while (sent < 380) begin
      if ($urandom_range(0, 5) == 0) begin
        r = $urandom_range(0, 3);
        set_wanted(r == 0 ? 7'd1 : r == 1 ? 7'd64 : r == 2 ? 7'd127 : 7'($urandom));
      end
      r = $urandom_range(0, 9);
      if (r < 6) sorted_run($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(0, 4));
      else if (r < 7) sorted_run($urandom_range(0, 16), $urandom_range(0, 16), 1000);
      else if (r < 8) sorted_run($urandom_range(1, 4), $urandom_range(1, 4), 0);
      else send_item(2'($urandom), $urandom);
      if ($urandom_range(0, 15) == 0) drain();
    end
    send_item(FUNC_RUN, 32'h0);
    drain();

    $display("Sent %0d items over %0d runs; %0d pairs checked.", sent, runs_seen, pairs_seen);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
